// ----- hdl/fpa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg: shared types and codes for the Q24.8 fixed-point ALU
// Opcodes and the queue entry between front and back ends.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_GT  = 4'd4;
    localparam logic [3:0] OP_LT  = 4'd5;
    localparam logic [3:0] OP_GE  = 4'd6;
    localparam logic [3:0] OP_LE  = 4'd7;
    localparam logic [3:0] OP_EQ  = 4'd8;
    localparam logic [3:0] OP_NE  = 4'd9;
    localparam logic [3:0] OP_MIN = 4'd10;
    localparam logic [3:0] OP_MAX = 4'd11;
    localparam logic [3:0] OP_INC = 4'd12;
    localparam logic [3:0] OP_DEC = 4'd13;
    localparam logic [3:0] OP_I2F = 4'd14;
    localparam logic [3:0] OP_F2I = 4'd15;

    // class of work decided at the front end
    localparam logic [1:0] CL_SIMPLE = 2'd0;
    localparam logic [1:0] CL_MUL    = 2'd1;
    localparam logic [1:0] CL_DIV    = 2'd2;

    typedef struct packed {
        logic [1:0]  cls;
        logic        neg;      // sign of mul/div result
        logic        dz;
        logic [31:0] ma;       // |a|
        logic [31:0] mb;       // |b|
        logic [31:0] res;      // finished result for simple ops
        logic        cmp;
    } fpa_entry_t;

    typedef struct packed {
        logic [31:0] res;
        logic        cmp;
        logic        dz;
        logic        ovf;
    } fpa_result_t;

endpackage

// ----- hdl/fpa_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_front: decode and classify
// Works out simple ops outright and prepares magnitudes for mul/div.
// ----------------------------------------------------------------------------
module fpa_front #(
    parameter int FRAC_BITS = 8
) (
    input  logic [3:0]          req_type,
    input  logic signed [31:0]  operand_a,
    input  logic signed [31:0]  operand_b,
    output fpa_pkg::fpa_entry_t entry
);

    logic        gt;
    logic        lt;
    logic        eq;
    logic [31:0] a;
    logic [31:0] b;

    always_comb
    begin
        a  = operand_a;
        b  = operand_b;
        gt = operand_a > operand_b;
        lt = operand_a < operand_b;
        eq = a == b;
        entry     = '0;
        entry.neg = a[31] ^ b[31];
        entry.ma  = a[31] ? (32'd0 - a) : a;
        entry.mb  = b[31] ? (32'd0 - b) : b;
        entry.cls = fpa_pkg::CL_SIMPLE;
        unique case (req_type)
            fpa_pkg::OP_ADD: entry.res = a + b;
            fpa_pkg::OP_SUB: entry.res = a - b;
            fpa_pkg::OP_MUL: entry.cls = fpa_pkg::CL_MUL;
            fpa_pkg::OP_DIV:
            begin
                if (b == 32'd0)
                    entry.dz = 1'b1;
                else
                    entry.cls = fpa_pkg::CL_DIV;
            end
            fpa_pkg::OP_GT:  entry.cmp = gt;
            fpa_pkg::OP_LT:  entry.cmp = lt;
            fpa_pkg::OP_GE:  entry.cmp = !lt;
            fpa_pkg::OP_LE:  entry.cmp = !gt;
            fpa_pkg::OP_EQ:  entry.cmp = eq;
            fpa_pkg::OP_NE:  entry.cmp = !eq;
            fpa_pkg::OP_MIN: entry.res = gt ? b : a;
            fpa_pkg::OP_MAX: entry.res = lt ? b : a;
            fpa_pkg::OP_INC: entry.res = a + 32'd1;
            fpa_pkg::OP_DEC: entry.res = a - 32'd1;
            fpa_pkg::OP_I2F: entry.res = a << FRAC_BITS;
            fpa_pkg::OP_F2I: entry.res = 32'(operand_a >>> FRAC_BITS);
            default:         entry.res = a;
        endcase
    end

endmodule

// ----- hdl/fpa_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_back: execution pipeline
// Fixed-depth pipeline: multiply split into 16-bit partial products,
// divide as an unrolled-over-stages restoring divider, two quotient bits
// per stage, then rounding and saturation. Stalls as a whole on hold.
// ----------------------------------------------------------------------------
module fpa_back #(
    parameter int FRAC_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 hold,
    input  logic                 in_valid,
    input  fpa_pkg::fpa_entry_t  in_entry,
    output logic                 out_valid,
    output fpa_pkg::fpa_result_t out_result
);

    // dividend is |a| << FRAC_BITS, then one extra bit for rounding
    localparam int NW     = 32 + FRAC_BITS + 1;
    localparam int DSTEPS = (NW + 1) / 2;
    localparam int QW     = 2 * DSTEPS;
    localparam int DEPTH  = DSTEPS + 2;

    typedef struct packed {
        logic [1:0]  cls;
        logic        neg;
        logic        dz;
        logic [31:0] res;
        logic        cmp;
        logic [31:0] mb;
        logic [QW-1:0] num;   // shifting dividend / quotient
        logic [32:0] rem;
        logic [63:0] prod;
    } stage_t;

    stage_t st_reg [DEPTH];
    logic   v_reg  [DEPTH];
    stage_t st_next [DEPTH];

    always_comb
    begin
        logic [33:0] r;
        logic [31:0] p0, p1, p2, p3;
        st_next[0]       = '0;
        st_next[0].cls   = in_entry.cls;
        st_next[0].neg   = in_entry.neg;
        st_next[0].dz    = in_entry.dz;
        st_next[0].res   = in_entry.res;
        st_next[0].cmp   = in_entry.cmp;
        st_next[0].mb    = in_entry.mb;
        // zero-padded at the top to an even bit count
        st_next[0].num   = QW'({in_entry.ma, FRAC_BITS'(0), 1'b0});
        p0 = 32'(in_entry.ma[15:0]) * 32'(in_entry.mb[15:0]);
        p1 = 32'(in_entry.ma[31:16]) * 32'(in_entry.mb[15:0]);
        p2 = 32'(in_entry.ma[15:0]) * 32'(in_entry.mb[31:16]);
        p3 = 32'(in_entry.ma[31:16]) * 32'(in_entry.mb[31:16]);
        st_next[0].rem  = 33'(p1) + 33'(p2);
        st_next[0].prod = {p3, p0};
        for (int s = 1; s < DEPTH; s++)
        begin
            st_next[s] = st_reg[s-1];
            if (s == 1)
            begin
                st_next[s].prod = st_reg[0].prod + (64'(st_reg[0].rem) << 16);
                st_next[s].rem  = '0;
            end
            else if (s <= DSTEPS + 1)
            begin
                for (int k = 0; k < 2; k++)
                begin
                    r = {st_next[s].rem, st_next[s].num[QW-1]};
                    st_next[s].num = {st_next[s].num[QW-2:0], 1'b0};
                    if (r >= 34'(st_next[s].mb))
                    begin
                        r = r - 34'(st_next[s].mb);
                        st_next[s].num[0] = 1'b1;
                    end
                    st_next[s].rem = r[32:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DEPTH; s++)
                v_reg[s] <= 1'b0;
        end
        else if (!hold)
        begin
            v_reg[0] <= in_valid;
            for (int s = 1; s < DEPTH; s++)
                v_reg[s] <= v_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold)
            for (int s = 0; s < DEPTH; s++)
                st_reg[s] <= st_next[s];
    end

    // final: round, sign, saturate
    stage_t      fin;
    logic [63:0] q;
    logic        ovf;
    logic [31:0] sat;

    always_comb
    begin
        fin = st_reg[DEPTH-1];
        if (fin.cls == fpa_pkg::CL_MUL)
            q = (fin.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        else
            // quotient of 2*num by den, +1 then halve gives half-up rounding
            q = (64'(fin.num) + 64'd1) >> 1;
        ovf = 1'b0;
        if (fin.neg)
        begin
            if (q > 64'h8000_0000)
            begin
                ovf = 1'b1;
                sat = 32'h8000_0000;
            end
            else
                sat = 32'd0 - q[31:0];
        end
        else if (q > 64'h7FFF_FFFF)
        begin
            ovf = 1'b1;
            sat = 32'h7FFF_FFFF;
        end
        else
            sat = q[31:0];
        out_result.cmp = fin.cmp;
        out_result.dz  = fin.dz;
        if (fin.cls == fpa_pkg::CL_SIMPLE)
        begin
            out_result.res = fin.res;
            out_result.ovf = 1'b0;
        end
        else
        begin
            out_result.res = sat;
            out_result.ovf = ovf;
        end
    end

    assign out_valid = v_reg[DEPTH-1];

endmodule

// ----- hdl/fpa_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_fifo: small register queue
// Holds entries between pipeline stages; count-based empty, count exported.
// ----------------------------------------------------------------------------
module fpa_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr,
    input  logic [W-1:0] wdata,
    input  logic         rd,
    output logic [W-1:0] rdata,
    output logic         empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] rp_reg;
    logic [CW-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            if (rd)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
            cnt_reg <= cnt_reg + CW'(wr) - CW'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wdata;
    end

    assign rdata = mem_reg[rp_reg];
    assign empty = cnt_reg == '0;
    assign count = cnt_reg;

endmodule

// ----- hdl/fixed_point_alu_q24_8.sv -----
`timescale 1ns / 1ps
// Path: an accepted item is registered in the entry queue, then passes the back
// stages (partial products, their sum, the divider stages) and is written into
// the result queue.
// Throughput: one item per cycle unless the credit check holds issue; the back
// pipeline runs the 2-bit-per-stage divider and split multiplier in lockstep.
// Reset: rst_n clears pointers and stage valid bits; data is not reset.
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8: signed fixed-point ALU
// Front decode, entry queue, back pipeline, result queue.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8 #(
    parameter int FRAC_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [3:0]         req_type,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] result_raw,
    output logic               compare_true,
    output logic               div_by_zero,
    output logic               overflow
);

    localparam int EW    = $bits(fpa_pkg::fpa_entry_t);
    localparam int RW    = $bits(fpa_pkg::fpa_result_t);
    // above the deepest back pipeline plus the pop round trip
    localparam int ODEP  = 32;
    localparam int OCW   = $clog2(ODEP + 1);

    fpa_pkg::fpa_entry_t  fe_entry;
    fpa_pkg::fpa_entry_t  q_entry;
    fpa_pkg::fpa_result_t b_result;
    fpa_pkg::fpa_result_t o_result;
    logic [EW-1:0] q_rdata;
    logic [RW-1:0] o_rdata;
    logic          q_empty;
    logic [2:0]    q_count;
    logic          issue;
    logic          b_valid;
    logic [OCW-1:0] o_count;
    logic [5:0]    fly_reg;
    logic          push_ok;
    logic          pop_ok;

    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;

    fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .req_type (req_type),
        .operand_a(operand_a),
        .operand_b(operand_b),
        .entry    (fe_entry)
    );

    fpa_fifo #(.W(EW), .DEPTH(4)) u_inq (
        .clk  (clk),
        .rst_n(rst_n),
        .wr   (push_ok),
        .wdata(fe_entry),
        .rd   (issue),
        .rdata(q_rdata),
        .empty(q_empty),
        .count(q_count)
    );

    assign q_entry = q_rdata;
    assign full    = q_count == 3'd4;

    // credit check: never issue more than the output queue can absorb
    assign issue = !q_empty && (OCW'(fly_reg) + o_count < OCW'(ODEP));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fly_reg <= '0;
        else
            fly_reg <= fly_reg + 6'(issue) - 6'(b_valid);
    end

    fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .hold      (1'b0),
        .in_valid  (issue),
        .in_entry  (q_entry),
        .out_valid (b_valid),
        .out_result(b_result)
    );

    fpa_fifo #(.W(RW), .DEPTH(ODEP)) u_outq (
        .clk  (clk),
        .rst_n(rst_n),
        .wr   (b_valid),
        .wdata(b_result),
        .rd   (pop_ok),
        .rdata(o_rdata),
        .empty(empty),
        .count(o_count)
    );

    assign o_result     = o_rdata;
    assign result_raw   = o_result.res;
    assign compare_true = o_result.cmp;
    assign div_by_zero  = o_result.dz;
    assign overflow     = o_result.ovf;

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        OCW'(fly_reg) + o_count <= OCW'(ODEP))
        else $error("output queue credit exceeded");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid |-> o_count != OCW'(ODEP))
        else $error("result written into full queue");

    a_dz_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && div_by_zero |-> !overflow && !compare_true && result_raw == 32'sd0)
        else $error("divide by zero flags inconsistent");

endmodule

// ----- tb/sv/tb_fixed_point_alu_q24_8.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_point_alu_q24_8: self-checking bench for the Q24.8 fixed-point ALU
// A directed table of edge cases is followed by random requests with bursty
// pushes and patterned pops; each result is checked against the table or a model.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu_q24_8;

    localparam int FRAC = 8;
    localparam int N_RANDOM = 1230;
    localparam int TIMEOUT = 400000;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] a;
        logic [31:0] b;
    } alu_req_t;

    typedef struct {
        alu_req_t             req;
        logic                 known;    // expected value typed into the table
        fpa_pkg::fpa_result_t res;
    } table_row_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [3:0]         req_type;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic               empty;
    logic               pop;
    logic signed [31:0] result_raw;
    logic               compare_true;
    logic               div_by_zero;
    logic               overflow;

    fpa_pkg::fpa_result_t awaited_results[$];
    table_row_t  edge_rows[$];
    int          n_errors = 0;
    int          cycle_count = 0;

    fixed_point_alu_q24_8 #(.FRAC_BITS(FRAC)) DUT (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .req_type(req_type), .operand_a(operand_a), .operand_b(operand_b),
        .empty(empty), .pop(pop), .result_raw(result_raw),
        .compare_true(compare_true), .div_by_zero(div_by_zero), .overflow(overflow)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] saturate_sign(logic [63:0] q, logic neg, output logic ovf);
        ovf = 1'b0;
        if (neg)
        begin
            if (q > 64'h8000_0000)
            begin
                ovf = 1'b1;
                return 32'h8000_0000;
            end
            return 32'(-q);
        end
        if (q > 64'h7FFF_FFFF)
        begin
            ovf = 1'b1;
            return 32'h7FFF_FFFF;
        end
        return q[31:0];
    endfunction

    function automatic fpa_pkg::fpa_result_t alu_outcome(alu_req_t r);
        fpa_pkg::fpa_result_t o;
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        logic neg;
        sa = r.a;
        sb = r.b;
        ma = {32'd0, r.a[31] ? 32'(-r.a) : r.a};
        mb = {32'd0, r.b[31] ? 32'(-r.b) : r.b};
        neg = r.a[31] ^ r.b[31];
        o = '0;
        case (r.op)
            fpa_pkg::OP_ADD: o.res = r.a + r.b;
            fpa_pkg::OP_SUB: o.res = r.a - r.b;
            fpa_pkg::OP_MUL:
            begin
                q = (ma * mb + (64'd1 << (FRAC - 1))) >> FRAC;
                o.res = saturate_sign(q, neg, o.ovf);
            end
            fpa_pkg::OP_DIV:
            begin
                if (r.b == 32'd0)
                    o.dz = 1'b1;
                else
                begin
                    q = (64'd2 * (ma << FRAC) + mb) / (64'd2 * mb);
                    o.res = saturate_sign(q, neg, o.ovf);
                end
            end
            fpa_pkg::OP_GT:  o.cmp = sa > sb;
            fpa_pkg::OP_LT:  o.cmp = sa < sb;
            fpa_pkg::OP_GE:  o.cmp = sa >= sb;
            fpa_pkg::OP_LE:  o.cmp = sa <= sb;
            fpa_pkg::OP_EQ:  o.cmp = sa == sb;
            fpa_pkg::OP_NE:  o.cmp = sa != sb;
            fpa_pkg::OP_MIN: o.res = (sa > sb) ? r.b : r.a;
            fpa_pkg::OP_MAX: o.res = (sa < sb) ? r.b : r.a;
            fpa_pkg::OP_INC: o.res = r.a + 32'd1;
            fpa_pkg::OP_DEC: o.res = r.a - 32'd1;
            fpa_pkg::OP_I2F: o.res = r.a << FRAC;
            default: o.res = 32'(sa >>> FRAC);
        endcase
        return o;
    endfunction

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'($signed($urandom_range(0, 1024)) - 512);
            3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            4: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_row(logic [3:0] op, logic [31:0] a, logic [31:0] b,
                           logic known = 1'b0, logic [31:0] res = '0,
                           logic cmp = 1'b0, logic dz = 1'b0, logic ovf = 1'b0);
        table_row_t row;
        row.req = '{op: op, a: a, b: b};
        row.known = known;
        row.res = '{res: res, cmp: cmp, dz: dz, ovf: ovf};
        edge_rows.push_back(row);
    endtask

    // drives the item and push, then waits for acceptance
    task automatic send_item(alu_req_t r);
        push <= 1'b1;
        req_type <= r.op;
        operand_a <= r.a;
        operand_b <= r.b;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    task automatic sender_gap();
        push <= 1'b0;
        repeat ($urandom_range(1, 6))
            @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result with nothing expected: res=%h", result_raw);
                n_errors++;
            end
            else
            begin
                fpa_pkg::fpa_result_t e;
                e = awaited_results.pop_front();
                if (result_raw !== e.res)
                begin
                    $error("result_raw: expected %h actual %h", e.res, result_raw);
                    n_errors++;
                end
                if (compare_true !== e.cmp)
                begin
                    $error("compare_true: expected %b actual %b", e.cmp, compare_true);
                    n_errors++;
                end
                if (div_by_zero !== e.dz)
                begin
                    $error("div_by_zero: expected %b actual %b", e.dz, div_by_zero);
                    n_errors++;
                end
                if (overflow !== e.ovf)
                begin
                    $error("overflow: expected %b actual %b", e.ovf, overflow);
                    n_errors++;
                end
            end
        end
    end

    // pop pattern: long open stretches, then a mostly-open phase and sparse random pops
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (cycle_count % 1500 < 400)
            pop <= 1'b1;
        else if (cycle_count % 1500 < 900)
            pop <= (cycle_count % 7) != 3;
        else
            pop <= ($urandom_range(0, 3) == 0);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT)
        begin
            $display("fixed_point_alu_q24_8 regression: fail");
            $finish;
        end
    end

    initial
    begin
        alu_req_t r;
        fpa_pkg::fpa_result_t e;
        int burst;
        int sent;
        rst_n = 1'b0;
        push = 1'b0;
        req_type = fpa_pkg::OP_ADD;
        operand_a = '0;
        operand_b = '0;

        add_row(fpa_pkg::OP_ADD, 32'h7FFF_FFFF, 32'd1, 1'b1, 32'h8000_0000);
        add_row(fpa_pkg::OP_SUB, 32'h8000_0000, 32'd1, 1'b1, 32'h7FFF_FFFF);
        add_row(fpa_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF,
                1'b0, 1'b0, 1'b1);
        add_row(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000,
                1'b0, 1'b0, 1'b1);
        add_row(fpa_pkg::OP_MUL, 32'h0000_0180, 32'hFFFF_FF80);
        add_row(fpa_pkg::OP_MUL, 32'h0000_0001, 32'h0000_0080);
        add_row(fpa_pkg::OP_MUL, 32'h8000_0000, 32'h0000_0100);
        add_row(fpa_pkg::OP_DIV, 32'h1234_5678, 32'd0, 1'b1, 32'd0, 1'b0, 1'b1, 1'b0);
        add_row(fpa_pkg::OP_DIV, 32'h8000_0000, 32'd0, 1'b1, 32'd0, 1'b0, 1'b1, 1'b0);
        add_row(fpa_pkg::OP_DIV, 32'h7FFF_FFFF, 32'd1, 1'b1, 32'h7FFF_FFFF,
                1'b0, 1'b0, 1'b1);
        add_row(fpa_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF,
                1'b0, 1'b0, 1'b1);
        add_row(fpa_pkg::OP_DIV, 32'h0000_0100, 32'h0000_0300);
        add_row(fpa_pkg::OP_DIV, 32'hFFFF_FF00, 32'h0000_0200);
        add_row(fpa_pkg::OP_GT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'd0, 1'b0);
        add_row(fpa_pkg::OP_LT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'd0, 1'b1);
        add_row(fpa_pkg::OP_GE, 32'h0000_0005, 32'h0000_0005, 1'b1, 32'd0, 1'b1);
        add_row(fpa_pkg::OP_LE, 32'h0000_0006, 32'h0000_0005, 1'b1, 32'd0, 1'b0);
        add_row(fpa_pkg::OP_EQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b1);
        add_row(fpa_pkg::OP_NE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0);
        add_row(fpa_pkg::OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000);
        add_row(fpa_pkg::OP_MAX, 32'h0000_0009, 32'h0000_0009, 1'b1, 32'h0000_0009);
        add_row(fpa_pkg::OP_INC, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000);
        add_row(fpa_pkg::OP_DEC, 32'h8000_0000, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF);
        add_row(fpa_pkg::OP_I2F, 32'h00FF_FFFF, 32'd0, 1'b1, 32'hFFFF_FF00);
        add_row(fpa_pkg::OP_F2I, 32'hFFFF_FF01, 32'd0, 1'b1, 32'hFFFF_FFFF);

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (edge_rows[i])
        begin
            r = edge_rows[i].req;
            e = alu_outcome(r);
            if (edge_rows[i].known && e !== edge_rows[i].res)
            begin
                $error("table row %0d: typed result %h, model gives %h",
                       i, edge_rows[i].res, e);
                n_errors++;
            end
            awaited_results.push_back(edge_rows[i].known ? edge_rows[i].res : e);
            send_item(r);
        end
        push <= 1'b0;
        // hold off until the queue drains
        while (awaited_results.size() != 0)
            @(posedge clk);

        sent = 0;
        while (sent < N_RANDOM)
        begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && sent < N_RANDOM)
            begin
                r.op = 4'($urandom_range(0, 15));
                r.a = pick_operand();
                r.b = ($urandom_range(0, 9) == 0) ? r.a : pick_operand();
                awaited_results.push_back(alu_outcome(r));
                send_item(r);
                burst--;
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                sender_gap();
        end
        push <= 1'b0;

        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
        if (n_errors == 0)
            $display("fixed_point_alu_q24_8 regression: pass");
        else
            $display("fixed_point_alu_q24_8 regression: fail");
        $finish;
    end
endmodule
